### rtl/core/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

    localparam int PAGES_DEF     = 65536;
    localparam int PAGE_SHIFT    = 12;
    localparam int WORD_BITS     = 32;
    localparam int WORD_SHIFT    = 5;

    localparam int SIZE_W        = 29;
    localparam int ALIGN_W       = 29;
    localparam int ADDR_W        = 28;
    localparam int FSP_W         = 16;
    localparam int PCNT_W        = 17;
    localparam int PAGES_REQ_W   = SIZE_W - PAGE_SHIFT + 1;

    localparam int PADDR_W       = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [PCNT_W-1:0] PCNT_RESET = PCNT_W'(65536);

    typedef enum logic {
        REG_FIRST_SEARCH = 1'b0,
        REG_PAGE_COUNT   = 1'b1
    } t_reg_idx;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_mode;

    typedef enum logic {
        STATUS_OK  = 1'b0,
        STATUS_OOM = 1'b1
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

### rtl/core/bpa_map_ram.sv
`default_nettype none

module bpa_map_ram
    import bpa_pkg::*;
#(
    parameter int WORDS = PAGES_DEF / WORD_BITS,
    parameter int AW    = $clog2(PAGES_DEF / WORD_BITS),
    parameter int WB    = WORD_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [WB-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [WB-1:0] o_rdata
);

    logic [WB-1:0] r_mem [WORDS];
    logic [WB-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/bpa_rem_div.sv
`default_nettype none

module bpa_rem_div
    import bpa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [FSP_W-1:0]   i_dividend,
    input  wire logic [ALIGN_W-1:0] i_divisor,
    output logic                    o_done,
    output logic      [FSP_W-1:0]   o_rem
);

    localparam int CNT_W = $clog2(FSP_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [FSP_W-1:0]   r_dvd;
    logic [FSP_W-1:0]   r_acc;

    logic [FSP_W:0]     trial;
    logic [ALIGN_W-1:0] trial_ext;
    logic               fits;

    // restoring remainder, one dividend bit per cycle
    always_comb begin
        trial     = {r_acc, r_dvd[FSP_W-1]};
        trial_ext = ALIGN_W'(trial);
        fits      = (trial_ext >= i_divisor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FSP_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_acc <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_acc <= fits ? FSP_W'(trial_ext - i_divisor) : FSP_W'(trial);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_acc;

endmodule

`default_nettype wire

### rtl/core/bitmap_page_allocator.sv
// allocate: setup computes the start-page remainder, then the scan reads the map word
//   by word and tests it page by page; wholly used or wholly free words are skipped as a
//   unit when the alignment step is 32 pages or more; marking reads and writes back each word
// free: each map word touched is read and written back; one request in flight at a time
// after reset the page map is cleared to all used, one 32-bit word a cycle (PAGES/32
//   words, 2048 by default); requests stall during this pass, register writes do not
`default_nettype none

module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int PAGES = PAGES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,

    input  wire logic                  i_req_valid,
    output logic                       o_req_stall,
    input  wire logic                  i_mode,
    input  wire logic [SIZE_W-1:0]     i_size_bytes,
    input  wire logic [ALIGN_W-1:0]    i_align_bytes,
    input  wire logic [ADDR_W-1:0]     i_free_address,

    output logic                       o_rsp_valid,
    input  wire logic                  i_rsp_stall,
    output logic      [ADDR_W-1:0]     o_address,
    output logic                       o_status
);

    localparam int WB    = WORD_BITS;
    localparam int WORDS = (PAGES + WB - 1) / WB;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = $clog2(PAGES + 1);
    localparam int CMPW  = ((PW > PAGES_REQ_W) ? PW : PAGES_REQ_W) + 1;
    localparam int SW    = ALIGN_W;
    localparam int FPG_W = ADDR_W - PAGE_SHIFT;

    // page step between aligned starts: align / gcd(align, page size)
    function automatic logic [SW-1:0] page_step(input logic [SW-1:0] align);
        logic [SW-1:0] a;
        logic [3:0]    tz;
        a  = (align == '0) ? SW'(1) : align;
        tz = 4'(PAGE_SHIFT);
        for (int i = PAGE_SHIFT - 1; i >= 0; i--) begin
            if (a[i]) begin
                tz = 4'(i);
            end
        end
        return a >> tz;
    endfunction

    function automatic logic [AW-1:0] word_of(input logic [PW-1:0] pg);
        return AW'(pg >> WORD_SHIFT);
    endfunction

    // configuration
    logic [FSP_W-1:0]  r_fsp;
    logic [PCNT_W-1:0] r_pcnt;
    logic              cfg_wr;
    t_reg_idx          cfg_sel;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = t_reg_idx'(paddr[PADDR_W-1]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsp  <= '0;
            r_pcnt <= PCNT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_FIRST_SEARCH: r_fsp  <= pwdata[FSP_W-1:0];
                REG_PAGE_COUNT:   r_pcnt <= pwdata[PCNT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_FIRST_SEARCH: prdata = APB_DATA_W'(r_fsp);
            REG_PAGE_COUNT:   prdata = APB_DATA_W'(r_pcnt);
        endcase
    end

    // state
    t_state                 r_state, n_state;
    logic                   r_mode, n_mode;
    logic [FPG_W-1:0]       r_faddr_pg, n_faddr_pg;
    logic [PAGES_REQ_W-1:0] r_pages, n_pages;
    logic [SW-1:0]          r_step, n_step;
    logic [PW-1:0]          r_p, n_p;
    logic [PW-1:0]          r_rem, n_rem;
    logic                   r_cand, n_cand;
    logic [PW-1:0]          r_start, n_start;
    logic [PW-1:0]          r_len, n_len;
    logic [PW-1:0]          r_lo, n_lo;
    logic [PW-1:0]          r_hm1, n_hm1;
    logic                   r_val, n_val;
    logic [AW-1:0]          r_rd_w, n_rd_w;
    logic [AW-1:0]          r_last_w, n_last_w;
    logic [AW-1:0]          r_wr_w, n_wr_w;
    logic                   r_rd_more, n_rd_more;
    logic                   r_pend, n_pend;
    logic [ADDR_W-1:0]      r_res_addr, n_res_addr;
    logic                   r_res_status, n_res_status;
    logic                   r_out_valid;
    logic [ADDR_W-1:0]      r_out_addr;
    logic                   r_out_status;

    // map memory and remainder unit
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [WB-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [WB-1:0] mem_q;
    logic          div_start;
    logic          div_done;
    logic [FSP_W-1:0] div_rem;

    bpa_map_ram #(
        .WORDS (WORDS),
        .AW    (AW),
        .WB    (WB)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    bpa_rem_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_fsp),
        .i_divisor  (r_step),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // datapath terms
    logic [PAGES_REQ_W-1:0] req_pages;
    logic [SW-1:0]          req_step;
    logic [CMPW-1:0]        cnt_ext;
    logic [CMPW-1:0]        free_end;
    logic [CMPW-1:0]        free_hi;
    logic [SW-1:0]          rem_p1;
    logic [SW-1:0]          rem_pw;
    logic [PW-1:0]          rem_1;
    logic [PW-1:0]          rem_w;
    logic                   aligned;
    logic                   step_ge_w;
    logic                   word_room;
    logic                   at_word_start;
    logic                   cur_free;
    logic                   fast_used;
    logic                   fast_free;
    logic [PW-1:0]          len_next;
    logic [PW-1:0]          hit_start;
    logic [PW-1:0]          hit_hm1;
    logic                   hit;
    logic [WORD_SHIFT-1:0]  lo_off;
    logic [WORD_SHIFT-1:0]  hi_off;
    logic [WB-1:0]          run_mask;
    logic                   req_acc;
    logic                   out_load;

    always_comb begin
        req_pages = PAGES_REQ_W'(i_size_bytes[SIZE_W-1:PAGE_SHIFT])
                  + PAGES_REQ_W'(|i_size_bytes[PAGE_SHIFT-1:0]);
        req_step  = page_step(i_align_bytes);

        cnt_ext  = (CMPW'(r_pcnt) > CMPW'(PAGES)) ? CMPW'(PAGES) : CMPW'(r_pcnt);
        free_end = CMPW'(r_faddr_pg) + CMPW'(r_pages);
        free_hi  = (free_end > cnt_ext) ? cnt_ext : free_end;

        // running page index modulo the alignment step
        rem_p1    = SW'(r_rem) + SW'(1);
        rem_1     = (rem_p1 == r_step) ? '0 : PW'(rem_p1);
        rem_pw    = SW'(r_rem) + SW'(WB);
        rem_w     = PW'((rem_pw >= r_step) ? rem_pw - r_step : rem_pw);
        aligned   = (r_rem == '0);
        step_ge_w = (r_step >= SW'(WB));

        at_word_start = (r_p[WORD_SHIFT-1:0] == '0);
        word_room     = ((CMPW'(r_p) + CMPW'(WB)) <= cnt_ext);
        cur_free      = mem_q[r_p[WORD_SHIFT-1:0]];
        fast_used     = at_word_start && !r_cand && (mem_q == '0) && step_ge_w && word_room;
        fast_free     = at_word_start && r_cand && (mem_q == '1) && step_ge_w && word_room
                        && ((CMPW'(r_len) + CMPW'(WB)) < CMPW'(r_pages));

        len_next  = r_cand ? (r_len + PW'(1)) : PW'(1);
        hit_start = r_cand ? r_start : r_p;
        hit       = cur_free && (r_cand || aligned) && (CMPW'(len_next) >= CMPW'(r_pages));
        hit_hm1   = PW'(CMPW'(hit_start) + CMPW'(r_pages) - CMPW'(1));

        // bits of the word being written back that fall inside the run
        lo_off   = (r_wr_w == word_of(r_lo)) ? r_lo[WORD_SHIFT-1:0] : '0;
        hi_off   = (r_wr_w == r_last_w) ? r_hm1[WORD_SHIFT-1:0] : '1;
        run_mask = ({WB{1'b1}} << lo_off) & ({WB{1'b1}} >> (WORD_SHIFT'(WB - 1) - hi_off));
    end

    assign o_req_stall = (r_state != ST_IDLE);
    assign req_acc     = i_req_valid && !o_req_stall;
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || !i_rsp_stall);

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_faddr_pg   = r_faddr_pg;
        n_pages      = r_pages;
        n_step       = r_step;
        n_p          = r_p;
        n_rem        = r_rem;
        n_cand       = r_cand;
        n_start      = r_start;
        n_len        = r_len;
        n_lo         = r_lo;
        n_hm1        = r_hm1;
        n_val        = r_val;
        n_rd_w       = r_rd_w;
        n_last_w     = r_last_w;
        n_wr_w       = r_wr_w;
        n_rd_more    = r_rd_more;
        n_pend       = r_pend;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        mem_we       = 1'b0;
        mem_waddr    = r_wr_w;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = r_rd_w;
        div_start    = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_rd_w;
                n_rd_w    = r_rd_w + AW'(1);
                if (r_rd_w == AW'(WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_mode     = i_mode;
                    n_faddr_pg = i_free_address[ADDR_W-1:PAGE_SHIFT];
                    n_pages    = req_pages;
                    n_step     = req_step;
                    n_state    = ST_PREP;
                end
            end
            ST_PREP: begin
                n_res_addr   = '0;
                n_res_status = STATUS_OK;
                if (r_mode == MODE_FREE) begin
                    if (CMPW'(r_faddr_pg) < free_hi) begin
                        n_lo      = PW'(r_faddr_pg);
                        n_hm1     = PW'(free_hi - CMPW'(1));
                        n_val     = 1'b1;
                        n_rd_w    = word_of(PW'(r_faddr_pg));
                        n_last_w  = word_of(PW'(free_hi - CMPW'(1)));
                        n_rd_more = 1'b1;
                        n_pend    = 1'b0;
                        n_state   = ST_RUN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else if (CMPW'(r_fsp) >= cnt_ext) begin
                    n_res_status = STATUS_OOM;
                    n_state      = ST_DONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_rem   = PW'(div_rem);
                    n_p     = PW'(r_fsp);
                    n_cand  = 1'b0;
                    n_len   = '0;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                mem_re    = 1'b1;
                mem_raddr = word_of(r_p);
                n_state   = ST_SCAN_EV;
            end
            ST_SCAN_EV: begin
                if (CMPW'(r_p) >= cnt_ext) begin
                    n_res_status = STATUS_OOM;
                    n_res_addr   = '0;
                    n_state      = ST_DONE;
                end else if (fast_used) begin
                    n_p     = r_p + PW'(WB);
                    n_rem   = rem_w;
                    n_state = ST_SCAN_RD;
                end else if (fast_free) begin
                    n_p     = r_p + PW'(WB);
                    n_rem   = rem_w;
                    n_len   = r_len + PW'(WB);
                    n_state = ST_SCAN_RD;
                end else begin
                    n_p   = r_p + PW'(1);
                    n_rem = rem_1;
                    if (cur_free) begin
                        if (r_cand) begin
                            n_len = len_next;
                        end else if (aligned) begin
                            n_cand  = 1'b1;
                            n_start = r_p;
                            n_len   = len_next;
                        end
                    end else begin
                        n_cand = 1'b0;
                    end
                    if (hit) begin
                        n_res_addr   = ADDR_W'(hit_start) << PAGE_SHIFT;
                        n_res_status = STATUS_OK;
                        if (r_pages == '0) begin
                            n_state = ST_DONE;
                        end else begin
                            n_lo      = hit_start;
                            n_hm1     = hit_hm1;
                            n_val     = 1'b0;
                            n_rd_w    = word_of(hit_start);
                            n_last_w  = word_of(hit_hm1);
                            n_rd_more = 1'b1;
                            n_pend    = 1'b0;
                            n_state   = ST_RUN;
                        end
                    end else if (r_p[WORD_SHIFT-1:0] == '1) begin
                        n_state = ST_SCAN_RD;
                    end
                end
            end
            ST_RUN: begin
                // read one word ahead, write back the word read last cycle
                mem_re    = r_rd_more;
                mem_raddr = r_rd_w;
                if (r_rd_more) begin
                    n_rd_w    = r_rd_w + AW'(1);
                    n_rd_more = (r_rd_w != r_last_w);
                    n_wr_w    = r_rd_w;
                end
                n_pend = r_rd_more;
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr_w;
                    mem_wdata = r_val ? (mem_q | run_mask) : (mem_q & ~run_mask);
                    if (!r_rd_more) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_rd_w      <= '0;
            r_rd_more   <= 1'b0;
            r_pend      <= 1'b0;
            r_cand      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_w    <= n_rd_w;
            r_rd_more <= n_rd_more;
            r_pend    <= n_pend;
            r_cand    <= n_cand;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_faddr_pg   <= n_faddr_pg;
        r_pages      <= n_pages;
        r_step       <= n_step;
        r_p          <= n_p;
        r_rem        <= n_rem;
        r_start      <= n_start;
        r_len        <= n_len;
        r_lo         <= n_lo;
        r_hm1        <= n_hm1;
        r_val        <= n_val;
        r_last_w     <= n_last_w;
        r_wr_w       <= n_wr_w;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_address   = r_out_addr;
    assign o_status    = r_out_status;

    // the scan only reads the map
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN_RD || r_state == ST_SCAN_EV) |-> !mem_we)
        else $error("map written during scan");

    // write-back stays inside the run's words
    a_run_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && mem_we) |-> (mem_waddr <= r_last_w))
        else $error("run write past last word");

    // out of memory always reports address zero
    a_oom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_status) |-> (o_address == '0))
        else $error("out of memory with nonzero address");

    // reset always starts the clearing pass
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == ST_CLEAR))
        else $error("reset did not start map clear");

    // an accepted request always moves into setup
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> (r_state == ST_PREP))
        else $error("accepted request not started");

endmodule

`default_nettype wire
